FILE: hw/rtl/hlfr_pkg.sv
package hlfr_pkg;

    // longest accepted frame length (command byte plus payload bytes)
    localparam int unsigned MAX_FRAME_LEN = 189;

    localparam logic [7:0] SYNC_FIRST  = 8'h5A;
    localparam logic [7:0] SYNC_SECOND = 8'hA5;
    localparam logic [7:0] MIN_LEN     = 8'd2;
    localparam logic [7:0] MAX_LEN     = 8'(MAX_FRAME_LEN);
    // highest payload index that a legal frame can carry
    localparam logic [7:0] MAX_INDEX   = 8'(MAX_FRAME_LEN - 2);

    // parser phase codes
    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_SYNC1 = 3'd1;
    localparam logic [2:0] PH_SYNC2 = 3'd2;
    localparam logic [2:0] PH_CMD   = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;

    typedef struct packed {
        logic [7:0] frame_command;
        logic [7:0] data_byte;
        logic [7:0] data_index;
        logic       last_of_frame;
    } result_t;

    // a byte that restarts the scan: first header byte or keep hunting
    function automatic logic [2:0] rescan_one(input logic [7:0] b);
        return (b == SYNC_FIRST) ? PH_SYNC1 : PH_HUNT;
    endfunction

endpackage

FILE: hw/rtl/header_length_frame_receiver_unit.sv
// Frame receiver for serial bytes framed as 0x5A, 0xA5, length, command and
// then length-1 payload bytes, with length from 2 to 189 (a longer or shorter
// length is a header error). Bytes come in on the in_valid/in_stall channel,
// one item per byte; every payload byte leaves on the out_valid/out_stall
// channel with the frame's command, its index from zero and a last-of-frame
// flag, while header, length and command bytes give no output item. A bad
// header resynchronises like a sliding window: the oldest header byte is
// dropped and the rest rescanned, so a wrong second byte of 0x5A starts a new frame.
// A payload byte accepted into the input register is parsed there and lands in
// the result register once that register is free, and its item is offered from
// there; one byte is accepted every cycle, and the only thing that holds the
// input back is a payload byte waiting for a result register that is full and
// stalled.
module header_length_frame_receiver_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] frame_command,
    output logic [7:0] data_byte,
    output logic [7:0] data_index,
    output logic       last_of_frame
);

    // input register
    logic               in_valid_reg;
    logic [7:0]         byte_reg;

    // result register
    logic               out_valid_reg;
    hlfr_pkg::result_t  result_reg;

    logic               emit;
    hlfr_pkg::result_t  result;
    logic               out_free;
    logic               advance;
    logic               in_accept;

    // result register can take a new item this cycle
    assign out_free  = !out_valid_reg || !out_stall;
    // byte in the input register is parsed; bytes with no output never wait
    assign advance   = in_valid_reg && (!emit || out_free);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    hlfr_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (byte_reg),
        .emit    (emit),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && advance && emit)
        begin
            result_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_command = result_reg.frame_command;
    assign data_byte     = result_reg.data_byte;
    assign data_index    = result_reg.data_index;
    assign last_of_frame = result_reg.last_of_frame;

endmodule

FILE: hw/rtl/hlfr_parser.sv
module hlfr_parser
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [7:0]               rx_byte,
    output logic                     emit,
    output hlfr_pkg::result_t        result
);

    logic [2:0] phase_reg;
    logic [2:0] phase_next;
    logic [7:0] remaining_reg;
    logic [7:0] remaining_next;
    logic [7:0] command_reg;
    logic [7:0] command_next;
    logic [7:0] position_reg;
    logic [7:0] position_next;
    logic       last;

    assign emit = (phase_reg == hlfr_pkg::PH_DATA);
    assign last = (remaining_reg <= 8'd1);

    assign result.frame_command = command_reg;
    assign result.data_byte     = rx_byte;
    assign result.data_index    = position_reg;
    assign result.last_of_frame = last;

    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        command_next   = command_reg;
        position_next  = position_reg;
        case (phase_reg)
            hlfr_pkg::PH_SYNC1:
            begin
                phase_next = (rx_byte == hlfr_pkg::SYNC_SECOND) ? hlfr_pkg::PH_SYNC2
                                                                 : hlfr_pkg::rescan_one(rx_byte);
            end
            hlfr_pkg::PH_SYNC2:
            begin
                // out-of-range length drops both header bytes and rescans this one
                if (rx_byte < hlfr_pkg::MIN_LEN || rx_byte > hlfr_pkg::MAX_LEN)
                begin
                    phase_next = hlfr_pkg::rescan_one(rx_byte);
                end
                else
                begin
                    remaining_next = rx_byte;
                    phase_next     = hlfr_pkg::PH_CMD;
                end
            end
            hlfr_pkg::PH_CMD:
            begin
                command_next   = rx_byte;
                remaining_next = remaining_reg - 8'd1;
                position_next  = 8'd0;
                phase_next     = (remaining_reg == 8'd1) ? hlfr_pkg::PH_HUNT
                                                         : hlfr_pkg::PH_DATA;
            end
            hlfr_pkg::PH_DATA:
            begin
                position_next = position_reg + 8'd1;
                if (last)
                begin
                    remaining_next = 8'd0;
                    phase_next     = hlfr_pkg::PH_HUNT;
                end
                else
                begin
                    remaining_next = remaining_reg - 8'd1;
                end
            end
            default:
            begin
                // hunting, and unused codes treated as hunting
                phase_next = hlfr_pkg::rescan_one(rx_byte);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= hlfr_pkg::PH_HUNT;
            remaining_reg <= 8'd0;
            command_reg   <= 8'd0;
            position_reg  <= 8'd0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            command_reg   <= command_next;
            position_reg  <= position_next;
        end
    end

endmodule

FILE: hw/rtl/hlfr_checker.sv
module hlfr_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] frame_command,
    input logic [7:0] data_byte,
    input logic [7:0] data_index,
    input logic       last_of_frame
);

    // a held output item stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output item dropped while stalled");

    // a held output item keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(frame_command) && $stable(data_byte)
                                   && $stable(data_index) && $stable(last_of_frame))
        else $error("output payload changed while stalled");

    // input is only held back by a full, stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // no payload index beyond the longest legal frame
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> data_index <= hlfr_pkg::MAX_INDEX)
        else $error("payload index beyond longest frame");

    // the highest index is always the end of its frame
    a_index_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && data_index == hlfr_pkg::MAX_INDEX |-> last_of_frame)
        else $error("longest frame not closed");

endmodule

bind header_length_frame_receiver_unit hlfr_checker u_hlfr_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_command (frame_command),
    .data_byte     (data_byte),
    .data_index    (data_index),
    .last_of_frame (last_of_frame)
);

FILE: dv/testbench.sv
module testbench;

    // one row of the directed stimulus: the byte to send and, where the outcome
    // is obvious, the payload item that it must give (or that it gives none)
    typedef struct packed {
        logic [7:0]         rx;
        logic               pinned;
        logic               pin_emit;
        hlfr_pkg::result_t  pin_res;
    } stim_row_t;

    localparam int N_DIRECTED  = 24;
    localparam int RANDOM_BYTES = 1950;
    localparam int DRAIN_LIMIT = 20000;
    localparam int MAX_REPORTS = 10;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] frame_command;
    logic [7:0] data_byte;
    logic [7:0] data_index;
    logic       last_of_frame;

    // idling on both sides, switched off for one long stretch
    bit         gaps_on = 1'b1;

    // deframer state as the predictor sees it
    logic [2:0] phase;
    logic [7:0] left_count;
    logic [7:0] cur_command;
    logic [7:0] next_index;

    // payload items still owed by the block, oldest first
    hlfr_pkg::result_t  pending_payload [$];

    int         errors       = 0;
    int         bytes_fed    = 0;
    int         payload_seen = 0;
    int         frames_ended = 0;
    int         max_frames   = 0;

    // directed rows: header errors of every kind first, then a shortest frame
    // and a three-byte frame whose payload is left to the predictor
    stim_row_t  dir_rows [0:N_DIRECTED-1] = '{
        '{8'h00, 1'b1, 1'b0, '0},                          // hunting, ignored
        '{8'h5A, 1'b1, 1'b0, '0},
        '{8'h5A, 1'b1, 1'b0, '0},                          // repeated first byte restarts
        '{8'h00, 1'b1, 1'b0, '0},                          // wrong second byte, back to hunt
        '{8'h5A, 1'b1, 1'b0, '0},
        '{8'hA5, 1'b1, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, '0},                          // length below minimum
        '{8'h5A, 1'b1, 1'b0, '0},
        '{8'hA5, 1'b1, 1'b0, '0},
        '{8'hBE, 1'b1, 1'b0, '0},                          // one above longest length
        '{8'h5A, 1'b1, 1'b0, '0},
        '{8'hA5, 1'b1, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b0, '0},                          // largest length byte
        '{8'h5A, 1'b1, 1'b0, '0},
        '{8'hA5, 1'b1, 1'b0, '0},
        '{8'h02, 1'b1, 1'b0, '0},                          // shortest legal length
        '{8'hFF, 1'b1, 1'b0, '0},                          // command
        '{8'h00, 1'b1, 1'b1, '{8'hFF, 8'h00, 8'd0, 1'b1}}, // sole payload byte
        '{8'h5A, 1'b1, 1'b0, '0},
        '{8'hA5, 1'b1, 1'b0, '0},
        '{8'h03, 1'b1, 1'b0, '0},
        '{8'h00, 1'b1, 1'b0, '0},                          // command
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hAA, 1'b0, 1'b0, '0}
    };

    header_length_frame_receiver_unit DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_command (frame_command),
        .data_byte     (data_byte),
        .data_index    (data_index),
        .last_of_frame (last_of_frame)
    );

    // 4-unit clock period
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // step the predicted deframer by one accepted byte; a payload byte gives
    // one item carrying the held command, its index and the last marker
    task automatic parse_rx_byte(input logic [7:0] b, output bit emit,
                                 output hlfr_pkg::result_t r);
        logic is_last;
        emit = 1'b0;
        r    = '0;
        case (phase)
            hlfr_pkg::PH_SYNC1:
            begin
                // wrong second byte: drop the first and rescan this one
                if (b == hlfr_pkg::SYNC_SECOND)
                    phase = hlfr_pkg::PH_SYNC2;
                else
                    phase = (b == hlfr_pkg::SYNC_FIRST) ? hlfr_pkg::PH_SYNC1
                                                        : hlfr_pkg::PH_HUNT;
            end
            hlfr_pkg::PH_SYNC2:
            begin
                // out-of-range length is a header error, the length byte is rescanned
                if (b < hlfr_pkg::MIN_LEN || b > hlfr_pkg::MAX_LEN)
                    phase = (b == hlfr_pkg::SYNC_FIRST) ? hlfr_pkg::PH_SYNC1
                                                        : hlfr_pkg::PH_HUNT;
                else
                begin
                    left_count = b;
                    phase      = hlfr_pkg::PH_CMD;
                end
            end
            hlfr_pkg::PH_CMD:
            begin
                cur_command = b;
                left_count  = left_count - 8'd1;
                next_index  = 8'd0;
                phase       = (left_count == 8'd0) ? hlfr_pkg::PH_HUNT : hlfr_pkg::PH_DATA;
            end
            hlfr_pkg::PH_DATA:
            begin
                is_last = (left_count <= 8'd1);
                r.frame_command = cur_command;
                r.data_byte     = b;
                r.data_index    = next_index;
                r.last_of_frame = is_last;
                emit            = 1'b1;
                next_index      = next_index + 8'd1;
                if (is_last)
                begin
                    left_count = 8'd0;
                    phase      = hlfr_pkg::PH_HUNT;
                end
                else
                    left_count = left_count - 8'd1;
            end
            default:
                phase = (b == hlfr_pkg::SYNC_FIRST) ? hlfr_pkg::PH_SYNC1 : hlfr_pkg::PH_HUNT;
        endcase
    endtask

    // offer one byte at the falling edge, with random idle cycles first, and
    // return at the rising edge where it is taken
    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        bytes_fed++;
    endtask

    // send a byte and note whatever payload item the predictor owes for it
    task automatic feed(input logic [7:0] b);
        bit                 emit;
        hlfr_pkg::result_t  r;
        send_byte(b);
        parse_rx_byte(b, emit, r);
        if (emit)
            pending_payload.push_back(r);
    endtask

    // a well-formed frame with random command and payload
    task automatic feed_frame(input logic [7:0] len);
        feed(hlfr_pkg::SYNC_FIRST);
        feed(hlfr_pkg::SYNC_SECOND);
        feed(len);
        feed(8'($urandom_range(255)));
        repeat (len - 1)
            feed(8'($urandom_range(255)));
    endtask

    // compare one output item with the oldest expectation, field by field
    task automatic check_result(input hlfr_pkg::result_t want);
        bit bad;
        bad = (frame_command !== want.frame_command) || (data_byte !== want.data_byte)
              || (data_index !== want.data_index) || (last_of_frame !== want.last_of_frame);
        if (bad)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("mismatch: cmd %h/%h byte %h/%h index %0d/%0d last %b/%b (exp/got)",
                         want.frame_command, frame_command, want.data_byte, data_byte,
                         want.data_index, data_index, want.last_of_frame, last_of_frame);
        end
    endtask

    // output side: stall at random, dropped during the quiet stretch
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= gaps_on && ($urandom_range(99) < 12);
        end
    end

    // output monitor: every item taken is checked against the oldest one owed
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            payload_seen++;
            if (last_of_frame === 1'b1)
                frames_ended++;
            if (pending_payload.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected item: cmd %h byte %h index %0d last %b",
                             frame_command, data_byte, data_index, last_of_frame);
            end
            else
                check_result(pending_payload.pop_front());
        end
    end

    // stimulus
    initial
    begin
        bit                 emit;
        hlfr_pkg::result_t  r;
        int                 pick;
        int                 waited;
        logic [7:0]         len;
        logic [7:0]         b;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        rx_byte  = 8'h00;

        phase       = hlfr_pkg::PH_HUNT;
        left_count  = 8'd0;
        cur_command = 8'd0;
        next_index  = 8'd0;

        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part: pinned rows take their typed outcome, the rest the
        // predictor's, and the predictor is stepped in either case
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_byte(dir_rows[i].rx);
            parse_rx_byte(dir_rows[i].rx, emit, r);
            if (dir_rows[i].pinned)
            begin
                if (dir_rows[i].pin_emit)
                    pending_payload.push_back(dir_rows[i].pin_res);
            end
            else if (emit)
                pending_payload.push_back(r);
        end

        // random part: mostly good frames, the rest broken headers and noise
        while (bytes_fed < N_DIRECTED + RANDOM_BYTES)
        begin
            gaps_on = !(bytes_fed >= 700 && bytes_fed < 1100);
            pick    = $urandom_range(99);
            if (pick < 70)
            begin
                // frame lengths mostly short, now and then the longest
                if ($urandom_range(99) < 4)
                begin
                    len = hlfr_pkg::MAX_LEN;
                    max_frames++;
                end
                else if ($urandom_range(99) < 12)
                    len = 8'($urandom_range(64, 2));
                else
                    len = 8'($urandom_range(10, 2));
                feed_frame(len);
            end
            else if (pick < 80)
            begin
                // bad length: below minimum or beyond the longest
                case ($urandom_range(3))
                    0:       len = 8'd0;
                    1:       len = 8'd1;
                    default: len = 8'($urandom_range(255, hlfr_pkg::MAX_FRAME_LEN + 1));
                endcase
                feed(hlfr_pkg::SYNC_FIRST);
                feed(hlfr_pkg::SYNC_SECOND);
                feed(len);
            end
            else if (pick < 88)
            begin
                // first header byte followed by anything but the second
                b = 8'($urandom_range(255));
                if (b == hlfr_pkg::SYNC_SECOND)
                    b = hlfr_pkg::SYNC_FIRST;
                feed(hlfr_pkg::SYNC_FIRST);
                feed(b);
            end
            else
            begin
                repeat ($urandom_range(4, 1))
                    feed(8'($urandom_range(255)));
            end
        end

        gaps_on = 1'b1;
        @(negedge clk);
        in_valid <= 1'b0;

        // drain what is still owed, then keep watching for strays
        waited = 0;
        while (pending_payload.size() != 0)
        begin
            @(posedge clk);
            waited++;
            if (waited > DRAIN_LIMIT)
            begin
                $display("timed out with %0d items owed", pending_payload.size());
                $display("testbench: errors");
                $finish;
            end
        end
        repeat (8)
            @(posedge clk);

        $display("fed %0d bytes, checked %0d payload items over %0d frames",
                 bytes_fed, payload_seen, frames_ended);
        $display("%0d frames of the longest length, %0d failures", max_frames, errors);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // overall watchdog
    initial
    begin
        #400000;
        $display("testbench: errors");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/hlfr_pkg.sv
hw/rtl/hlfr_parser.sv
hw/rtl/header_length_frame_receiver_unit.sv
hw/rtl/hlfr_checker.sv
dv/testbench.sv
